[hdl/assert_macros.svh]
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define PMR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PMR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pmr_pkg.sv]
// shared constants, types and trig tables of the polar multiply unit
package pmr_pkg;

	localparam int RADIUS_BITS_DEF   = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int TRIG_FRAC    = 30;
	localparam int TRIG_BITS    = TRIG_FRAC + 1;
	localparam int Q30_ONE      = 1 << TRIG_FRAC;
	// pi / 180 in q30
	localparam int DEG_Q30      = 18740330;
	localparam int TAYLOR_TERMS = 24;

	localparam int FULL_TURN    = 360;
	localparam int QUARTER_TURN = 90;
	localparam int MOD_W        = 10;
	localparam int RED_W        = 9;
	localparam int DEG_W        = 7;

	localparam int DIGIT_BITS   = 4;
	localparam int CELL_COUNT   = (TRIG_BITS + DIGIT_BITS - 1) / DIGIT_BITS;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	typedef logic [TRIG_BITS-1:0] trig_t;
	typedef trig_t trig_tab_t [0:QUARTER_TURN-1];

	// taylor series of sin or cos for every whole degree of one quadrant
	function automatic trig_tab_t build_trig_table(input logic want_sin);
		trig_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] s;
		logic [63:0] ts;
		logic [63:0] c;
		logic [63:0] tc;
		for (int d = 0; d < QUARTER_TURN; d++) begin
			x  = 64'(d) * 64'(DEG_Q30);
			x2 = (x * x) >> TRIG_FRAC;
			s  = x;
			ts = x;
			c  = 64'(Q30_ONE);
			tc = 64'(Q30_ONE);
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				ts = ((ts * x2) >> TRIG_FRAC) / 64'((2 * n) * (2 * n + 1));
				tc = ((tc * x2) >> TRIG_FRAC) / 64'((2 * n - 1) * (2 * n));
				if ((n & 1) != 0) begin
					s = s - ts;
					c = c - tc;
				end else begin
					s = s + ts;
					c = c + tc;
				end
			end
			tab[d] = want_sin ? s[TRIG_BITS-1:0] : c[TRIG_BITS-1:0];
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_trig_table(1'b1);
	localparam trig_tab_t COS_TAB = build_trig_table(1'b0);

endpackage

[hdl/pmr_front.sv]
// front pipeline: angle sum, radius product, mod 360 reduction and trig lookup
module pmr_front #(
	parameter int RADIUS_BITS = pmr_pkg::RADIUS_BITS_DEF,
	parameter int ANGLE_BITS  = pmr_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ANGLE_BITS-1:0]  angle_a,
	input  logic signed [RADIUS_BITS-1:0] radius_a,
	input  logic signed [ANGLE_BITS-1:0]  angle_b,
	input  logic signed [RADIUS_BITS-1:0] radius_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ANGLE_BITS:0]    out_sum,
	output logic signed [2*RADIUS_BITS-1:0] out_prod,
	output logic [2*RADIUS_BITS-1:0]      out_mag,
	output pmr_pkg::trig_t                out_cos,
	output pmr_pkg::trig_t                out_sin,
	output logic                          out_re_neg,
	output logic                          out_im_neg
);
	import pmr_pkg::*;

	localparam int SUM_W   = ANGLE_BITS + 1;
	localparam int PROD_W  = 2 * RADIUS_BITS;
	localparam int U_W     = ANGLE_BITS + 2;
	localparam int OFFSET  = FULL_TURN * ((2 ** ANGLE_BITS + FULL_TURN - 1) / FULL_TURN);
	localparam int RECIP   = (2 ** U_W) / FULL_TURN;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int Q_W     = U_W - $clog2(FULL_TURN) + 1;
	localparam int QP_W    = U_W + RECIP_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic ce_s1, ce_s2, ce_s3, ce_s4, ce_s5;

	logic signed [SUM_W-1:0]  sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;
	logic signed [PROD_W-1:0] prod_s1, prod_s2, prod_s3, prod_s4, prod_s5;
	logic [PROD_W-1:0]        mag_s2, mag_s3, mag_s4, mag_s5;
	logic                     pneg_s2, pneg_s3, pneg_s4;
	logic [U_W-1:0]           u_s2;
	logic [Q_W-1:0]           q_s2;
	logic [MOD_W-1:0]         r_s3;
	logic [RED_W-1:0]         r_s4;
	trig_t                    cos_s5, sin_s5;
	logic                     re_neg_s5, im_neg_s5;

	logic [U_W-1:0]    u_c;
	logic [QP_W-1:0]   qp_c;
	logic [PROD_W-1:0] mag_c;
	logic [U_W-1:0]    rem_c;
	quad_t             quad_c;
	logic [DEG_W-1:0]  deg_c;
	trig_t             sn_c, cs_c;
	trig_t             cos_c, sin_c;
	logic              cos_neg_c, sin_neg_c;

	// bubbles collapse: a stage loads when it is empty or its successor moves
	assign ce_s5    = !v_s5 || out_ready;
	assign ce_s4    = !v_s4 || ce_s5;
	assign ce_s3    = !v_s3 || ce_s4;
	assign ce_s2    = !v_s2 || ce_s3;
	assign ce_s1    = !v_s1 || ce_s2;
	assign in_ready = ce_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ce_s1) v_s1 <= in_valid;
			if (ce_s2) v_s2 <= v_s1;
			if (ce_s3) v_s3 <= v_s2;
			if (ce_s4) v_s4 <= v_s3;
			if (ce_s5) v_s5 <= v_s4;
		end
	end

	// offset by a whole number of turns so the reduction sees a positive value
	assign u_c   = U_W'(sum_s1) + U_W'(OFFSET);
	assign qp_c  = QP_W'(u_c) * QP_W'(RECIP);
	assign mag_c = prod_s1[PROD_W-1] ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	assign rem_c = u_s2 - U_W'(q_s2) * U_W'(FULL_TURN);

	always_comb begin
		priority if (r_s4 >= RED_W'(3 * QUARTER_TURN)) begin
			quad_c = QUAD_IV;
			deg_c  = DEG_W'(r_s4 - RED_W'(3 * QUARTER_TURN));
		end else if (r_s4 >= RED_W'(2 * QUARTER_TURN)) begin
			quad_c = QUAD_III;
			deg_c  = DEG_W'(r_s4 - RED_W'(2 * QUARTER_TURN));
		end else if (r_s4 >= RED_W'(QUARTER_TURN)) begin
			quad_c = QUAD_II;
			deg_c  = DEG_W'(r_s4 - RED_W'(QUARTER_TURN));
		end else begin
			quad_c = QUAD_I;
			deg_c  = DEG_W'(r_s4);
		end
	end

	assign sn_c = SIN_TAB[deg_c];
	assign cs_c = COS_TAB[deg_c];

	always_comb begin
		unique case (quad_c)
			QUAD_I: begin
				sin_c = sn_c; sin_neg_c = 1'b0; cos_c = cs_c; cos_neg_c = 1'b0;
			end
			QUAD_II: begin
				sin_c = cs_c; sin_neg_c = 1'b0; cos_c = sn_c; cos_neg_c = 1'b1;
			end
			QUAD_III: begin
				sin_c = sn_c; sin_neg_c = 1'b1; cos_c = cs_c; cos_neg_c = 1'b1;
			end
			QUAD_IV: begin
				sin_c = cs_c; sin_neg_c = 1'b1; cos_c = sn_c; cos_neg_c = 1'b0;
			end
			default: begin
				sin_c = sn_c; sin_neg_c = 1'b0; cos_c = cs_c; cos_neg_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce_s1) begin
			sum_s1  <= SUM_W'(angle_a) + SUM_W'(angle_b);
			prod_s1 <= PROD_W'(radius_a) * PROD_W'(radius_b);
		end
		if (ce_s2) begin
			sum_s2  <= sum_s1;
			prod_s2 <= prod_s1;
			mag_s2  <= mag_c;
			pneg_s2 <= prod_s1[PROD_W-1];
			u_s2    <= u_c;
			q_s2    <= Q_W'(qp_c >> U_W);
		end
		if (ce_s3) begin
			sum_s3  <= sum_s2;
			prod_s3 <= prod_s2;
			mag_s3  <= mag_s2;
			pneg_s3 <= pneg_s2;
			r_s3    <= rem_c[MOD_W-1:0];
		end
		if (ce_s4) begin
			sum_s4  <= sum_s3;
			prod_s4 <= prod_s3;
			mag_s4  <= mag_s3;
			pneg_s4 <= pneg_s3;
			r_s4    <= (r_s3 >= MOD_W'(FULL_TURN)) ? RED_W'(r_s3 - MOD_W'(FULL_TURN))
				: RED_W'(r_s3);
		end
		if (ce_s5) begin
			sum_s5    <= sum_s4;
			prod_s5   <= prod_s4;
			mag_s5    <= mag_s4;
			cos_s5    <= cos_c;
			sin_s5    <= sin_c;
			re_neg_s5 <= pneg_s4 ^ cos_neg_c;
			im_neg_s5 <= pneg_s4 ^ sin_neg_c;
		end
	end

	assign out_valid  = v_s5;
	assign out_sum    = sum_s5;
	assign out_prod   = prod_s5;
	assign out_mag    = mag_s5;
	assign out_cos    = cos_s5;
	assign out_sin    = sin_s5;
	assign out_re_neg = re_neg_s5;
	assign out_im_neg = im_neg_s5;

endmodule

[hdl/pmr_mul_cell.sv]
// one cell of the multiply chain: adds magnitude times one trig digit to both accumulators
module pmr_mul_cell #(
	parameter int ACC_W  = 2 * pmr_pkg::RADIUS_BITS_DEF + pmr_pkg::TRIG_BITS,
	parameter int SIDE_W = pmr_pkg::ANGLE_BITS_DEF + 1 + 2 * pmr_pkg::RADIUS_BITS_DEF + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACC_W-1:0]  in_mag,
	input  pmr_pkg::trig_t    in_cos,
	input  pmr_pkg::trig_t    in_sin,
	input  logic [ACC_W-1:0]  in_acc_re,
	input  logic [ACC_W-1:0]  in_acc_im,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ACC_W-1:0]  out_mag,
	output pmr_pkg::trig_t    out_cos,
	output pmr_pkg::trig_t    out_sin,
	output logic [ACC_W-1:0]  out_acc_re,
	output logic [ACC_W-1:0]  out_acc_im,
	output logic [SIDE_W-1:0] out_side
);
	import pmr_pkg::*;

	logic              valid_q;
	logic [ACC_W-1:0]  mag_q;
	trig_t             cos_q, sin_q;
	logic [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic [SIDE_W-1:0] side_q;
	logic [ACC_W-1:0]  pp_re_c, pp_im_c;

	assign in_ready = !valid_q || out_ready;

	// low digit of each trig value; the next cell sees the following digit
	assign pp_re_c = in_mag * ACC_W'(in_cos[DIGIT_BITS-1:0]);
	assign pp_im_c = in_mag * ACC_W'(in_sin[DIGIT_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			mag_q    <= in_mag << DIGIT_BITS;
			cos_q    <= in_cos >> DIGIT_BITS;
			sin_q    <= in_sin >> DIGIT_BITS;
			acc_re_q <= in_acc_re + pp_re_c;
			acc_im_q <= in_acc_im + pp_im_c;
			side_q   <= in_side;
		end
	end

	assign out_valid  = valid_q;
	assign out_mag    = mag_q;
	assign out_cos    = cos_q;
	assign out_sin    = sin_q;
	assign out_acc_re = acc_re_q;
	assign out_acc_im = acc_im_q;
	assign out_side   = side_q;

endmodule

[hdl/pmr_round.sv]
// output stage: drops the extra fraction bits, applies the sign and holds the result word
module pmr_round #(
	parameter int RADIUS_BITS   = pmr_pkg::RADIUS_BITS_DEF,
	parameter int ANGLE_BITS    = pmr_pkg::ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = pmr_pkg::FRACTION_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [2*RADIUS_BITS+pmr_pkg::TRIG_BITS-1:0] in_acc_re,
	input  logic [2*RADIUS_BITS+pmr_pkg::TRIG_BITS-1:0] in_acc_im,
	input  logic                                      in_re_neg,
	input  logic                                      in_im_neg,
	input  logic signed [ANGLE_BITS:0]                in_sum,
	input  logic signed [2*RADIUS_BITS-1:0]           in_prod,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [ANGLE_BITS:0]                out_sum,
	output logic signed [2*RADIUS_BITS-1:0]           out_prod,
	output logic signed [2*RADIUS_BITS+FRACTION_BITS-1:0] out_re,
	output logic signed [2*RADIUS_BITS+FRACTION_BITS-1:0] out_im
);
	import pmr_pkg::*;

	localparam int PART_W   = 2 * RADIUS_BITS + FRACTION_BITS;
	localparam int ROUND_SH = TRIG_FRAC - FRACTION_BITS;

	logic                     valid_q;
	logic signed [ANGLE_BITS:0]        sum_q;
	logic signed [2*RADIUS_BITS-1:0]   prod_q;
	logic signed [PART_W-1:0] re_q, im_q;
	logic [PART_W-1:0]        re_mag_c, im_mag_c;

	assign in_ready = !valid_q || out_ready;

	// the half lsb was already added at the head of the chain
	assign re_mag_c = PART_W'(in_acc_re >> ROUND_SH);
	assign im_mag_c = PART_W'(in_acc_im >> ROUND_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			sum_q  <= in_sum;
			prod_q <= in_prod;
			re_q   <= in_re_neg ? -re_mag_c : re_mag_c;
			im_q   <= in_im_neg ? -im_mag_c : im_mag_c;
		end
	end

	assign out_valid = valid_q;
	assign out_sum   = sum_q;
	assign out_prod  = prod_q;
	assign out_re    = re_q;
	assign out_im    = im_q;

endmodule

[hdl/polar_multiply_to_rectangular_unit.sv]
// top level of the polar multiply unit with rectangular output
//
// s_axis takes one word per cycle unless stalled, holding two polar numbers
// (angle in whole degrees, signed radius). m_axis returns the unreduced
// angle sum, the radius product and the real and imaginary parts of the
// product, signed with FRACTION_BITS fraction bits, rounded to nearest with
// ties away from zero. Scalar multiply: angle_b = 0 and radius_b = scalar.
// From acceptance to m_axis_tvalid a word passes 5 front stages (sum and
// product, two reciprocal steps and a correction of the mod 360 reduction,
// quadrant and table lookup), one multiply cell per 4-bit digit of the 31-bit
// trig value (8 cells) and the output register. Throughput is one word per
// cycle when not stalled. Every stage has its own valid bit and loads whenever
// it is empty, so when m_axis_tready is low the pipe keeps taking input until
// it is full; the result held on m_axis stays stable until taken. Reset
// empties all stages; there is no other state and nothing to set up.
module polar_multiply_to_rectangular_unit #(
	parameter int RADIUS_BITS   = pmr_pkg::RADIUS_BITS_DEF,
	parameter int ANGLE_BITS    = pmr_pkg::ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = pmr_pkg::FRACTION_BITS_DEF,
	localparam int IN_W  = ((2 * ANGLE_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((ANGLE_BITS + 1 + 6 * RADIUS_BITS + 2 * FRACTION_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// angle_a, radius_a, angle_b, radius_b
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// angle_sum, radius_product, real_part, imag_part
	output logic [OUT_W-1:0] m_axis_tdata
);
	import pmr_pkg::*;

	`include "assert_macros.svh"

	localparam int SUM_W    = ANGLE_BITS + 1;
	localparam int PROD_W   = 2 * RADIUS_BITS;
	localparam int PART_W   = 2 * RADIUS_BITS + FRACTION_BITS;
	localparam int ACC_W    = 2 * RADIUS_BITS + TRIG_BITS;
	localparam int SIDE_W   = SUM_W + PROD_W + 2;
	localparam int ROUND_SH = TRIG_FRAC - FRACTION_BITS;

	logic signed [ANGLE_BITS-1:0]  angle_a, angle_b;
	logic signed [RADIUS_BITS-1:0] radius_a, radius_b;

	logic                     f_valid, f_ready;
	logic signed [SUM_W-1:0]  f_sum;
	logic signed [PROD_W-1:0] f_prod;
	logic [PROD_W-1:0]        f_mag;
	trig_t                    f_cos, f_sin;
	logic                     f_re_neg, f_im_neg;

	logic              c_valid  [0:CELL_COUNT];
	logic              c_ready  [0:CELL_COUNT];
	logic [ACC_W-1:0]  c_mag    [0:CELL_COUNT];
	trig_t             c_cos    [0:CELL_COUNT];
	trig_t             c_sin    [0:CELL_COUNT];
	logic [ACC_W-1:0]  c_acc_re [0:CELL_COUNT];
	logic [ACC_W-1:0]  c_acc_im [0:CELL_COUNT];
	logic [SIDE_W-1:0] c_side   [0:CELL_COUNT];

	logic signed [SUM_W-1:0]  e_sum;
	logic signed [PROD_W-1:0] e_prod;
	logic                     e_re_neg, e_im_neg;

	logic signed [SUM_W-1:0]  r_sum;
	logic signed [PROD_W-1:0] r_prod;
	logic signed [PART_W-1:0] r_re, r_im;

	assign angle_a  = s_axis_tdata[ANGLE_BITS-1:0];
	assign radius_a = s_axis_tdata[ANGLE_BITS +: RADIUS_BITS];
	assign angle_b  = s_axis_tdata[ANGLE_BITS + RADIUS_BITS +: ANGLE_BITS];
	assign radius_b = s_axis_tdata[2 * ANGLE_BITS + RADIUS_BITS +: RADIUS_BITS];

	pmr_front #(
		.RADIUS_BITS(RADIUS_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.angle_a   (angle_a),
		.radius_a  (radius_a),
		.angle_b   (angle_b),
		.radius_b  (radius_b),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_sum   (f_sum),
		.out_prod  (f_prod),
		.out_mag   (f_mag),
		.out_cos   (f_cos),
		.out_sin   (f_sin),
		.out_re_neg(f_re_neg),
		.out_im_neg(f_im_neg)
	);

	// head of the chain: accumulators start at half an output lsb
	assign c_valid[0]  = f_valid;
	assign f_ready     = c_ready[0];
	assign c_mag[0]    = ACC_W'(f_mag);
	assign c_cos[0]    = f_cos;
	assign c_sin[0]    = f_sin;
	assign c_acc_re[0] = ACC_W'(1) << (ROUND_SH - 1);
	assign c_acc_im[0] = ACC_W'(1) << (ROUND_SH - 1);
	assign c_side[0]   = {f_sum, f_prod, f_re_neg, f_im_neg};

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		pmr_mul_cell #(
			.ACC_W (ACC_W),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_mag    (c_mag[i]),
			.in_cos    (c_cos[i]),
			.in_sin    (c_sin[i]),
			.in_acc_re (c_acc_re[i]),
			.in_acc_im (c_acc_im[i]),
			.in_side   (c_side[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_mag   (c_mag[i+1]),
			.out_cos   (c_cos[i+1]),
			.out_sin   (c_sin[i+1]),
			.out_acc_re(c_acc_re[i+1]),
			.out_acc_im(c_acc_im[i+1]),
			.out_side  (c_side[i+1])
		);
	end

	assign {e_sum, e_prod, e_re_neg, e_im_neg} = c_side[CELL_COUNT];

	pmr_round #(
		.RADIUS_BITS  (RADIUS_BITS),
		.ANGLE_BITS   (ANGLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (c_valid[CELL_COUNT]),
		.in_ready (c_ready[CELL_COUNT]),
		.in_acc_re(c_acc_re[CELL_COUNT]),
		.in_acc_im(c_acc_im[CELL_COUNT]),
		.in_re_neg(e_re_neg),
		.in_im_neg(e_im_neg),
		.in_sum   (e_sum),
		.in_prod  (e_prod),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_sum  (r_sum),
		.out_prod (r_prod),
		.out_re   (r_re),
		.out_im   (r_im)
	);

	assign m_axis_tdata = OUT_W'({r_im, r_re, r_prod, r_sum});

	// zero angle: cos is exactly one and sin exactly zero
	`PMR_ASSERT_IMP(a_zero_angle_exact, m_axis_tvalid && (r_sum == '0), (r_im == '0) && (r_re == (PART_W'(r_prod) <<< FRACTION_BITS)), "zero angle sum must give exact scaled product")
	// quarter turn: no real part
	`PMR_ASSERT_IMP(a_quarter_turn_real, m_axis_tvalid && (r_sum == SUM_W'(QUARTER_TURN)), r_re == '0, "ninety degrees must give zero real part")
	// an empty output register lets ready reach the input through the chain
	`PMR_ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input stalled while output register is empty")
	// a result that is taken while nothing is behind it leaves the port empty
	`PMR_ASSERT_NXT(a_drain, m_axis_tvalid && m_axis_tready && !c_valid[CELL_COUNT], !m_axis_tvalid, "output word repeated")

endmodule
